@@ src/pifs_pkg.sv @@
// shared types and constants of the particle impulse friction step block
package pifs_pkg;

  // request codes
  localparam logic [1:0] REQ_STEP    = 2'd0;
  localparam logic [1:0] REQ_LOAD    = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MASS       = 3'd0;
  localparam logic [2:0] CFG_RECIP_MASS = 3'd1;
  localparam logic [2:0] CFG_DRIFT_X    = 3'd2;
  localparam logic [2:0] CFG_DRIFT_Y    = 3'd3;
  localparam logic [2:0] CFG_DRIFT_Z    = 3'd4;
  localparam logic [2:0] CFG_EMITTER_X  = 3'd5;
  localparam logic [2:0] CFG_EMITTER_Y  = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL,
    OP_UPD_A,
    OP_UPD_B,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT_X,
    OP_DIV_INIT_Y,
    OP_DIV_STEP,
    OP_FRIC,
    OP_LOAD,
    OP_REFRESH,
    OP_OUT
  } op_t;

  // multiplier operand pairs, first six in issue order of a step
  typedef enum logic [2:0] {
    MUL_IX_RM,
    MUL_IY_RM,
    MUL_IV_RM,
    MUL_AX_AX,
    MUL_AY_AY,
    MUL_M_M,
    MUL_M_AX,
    MUL_M_AY
  } mul_sel_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic sq_gt;
  } status_t;

  localparam int SUM_W = 68;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > $signed({36'd0, 32'h7FFF_FFFF})) begin
      return 32'sh7FFF_FFFF;
    end else if (v < $signed({36'hF_FFFF_FFFF, 32'h8000_0000})) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ src/pifs_in_if.sv @@
// input channel: request code and impulse payload
interface pifs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] impulse_x;
  logic signed [31:0] impulse_y;
  logic signed [31:0] impulse_z;
  modport source(output valid, req_type, impulse_x, impulse_y, impulse_z, input ready);
  modport sink(input valid, req_type, impulse_x, impulse_y, impulse_z, output ready);
endinterface

@@ src/pifs_out_if.sv @@
// result channel: particle state after one item
interface pifs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] elev_out;
  logic signed [31:0] imp_x_out;
  logic signed [31:0] imp_y_out;
  logic signed [31:0] imp_v_out;
  modport source(output valid, pos_x, pos_y, elev_out, imp_x_out, imp_y_out, imp_v_out,
                 input ready);
  modport sink(input valid, pos_x, pos_y, elev_out, imp_x_out, imp_y_out, imp_v_out,
               output ready);
endinterface

@@ src/pifs_cfg_if.sv @@
// configuration write channel
interface pifs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/pifs_ctrl.sv @@
// sequencing controller of the particle step
module pifs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_req_type,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output pifs_pkg::cmd_t     cmd,
  input  pifs_pkg::status_t  st
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_UPD_A, S_UPD_B, S_CHECK, S_SQRT, S_MUL2, S_MWAIT,
    S_DIVX, S_DIVY, S_DIVY_RUN, S_FRIC, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = pifs_pkg::OP_NONE;
    cmd.mul_sel   = pifs_pkg::MUL_IX_RM;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = 5'd0;
          unique case (in_req_type)
            pifs_pkg::REQ_STEP: state_nxt = S_MUL;
            pifs_pkg::REQ_LOAD: begin
              cmd.op    = pifs_pkg::OP_LOAD;
              state_nxt = S_FINISH;
            end
            pifs_pkg::REQ_REFRESH: begin
              cmd.op    = pifs_pkg::OP_REFRESH;
              state_nxt = S_FINISH;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_MUL: begin
        cmd.op      = pifs_pkg::OP_MUL;
        cmd.mul_sel = pifs_pkg::mul_sel_t'(cnt_r[2:0]);
        if (cnt_r == 5'd5) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_UPD_A;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_UPD_A: begin
        cmd.op    = pifs_pkg::OP_UPD_A;
        state_nxt = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.op    = pifs_pkg::OP_UPD_B;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.sq_gt) begin
          cmd.op    = pifs_pkg::OP_SQRT_INIT;
          cnt_nxt   = 5'd0;
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_FRIC;
        end
      end
      S_SQRT: begin
        cmd.op  = pifs_pkg::OP_SQRT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.op      = pifs_pkg::OP_MUL;
        cmd.mul_sel = (cnt_r == 5'd0) ? pifs_pkg::MUL_M_AX : pifs_pkg::MUL_M_AY;
        if (cnt_r == 5'd1) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_MWAIT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_MWAIT: begin
        cmd.op    = pifs_pkg::OP_DIV_INIT_X;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd.op  = pifs_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.op    = pifs_pkg::OP_DIV_INIT_Y;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIVY_RUN;
      end
      S_DIVY_RUN: begin
        cmd.op  = pifs_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_FRIC;
        end
      end
      S_FRIC: begin
        cmd.op    = pifs_pkg::OP_FRIC;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = pifs_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/pifs_datapath.sv @@
// datapath: config registers, particle state, multiplier, square root and divider
module pifs_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] imp_x,
  input  logic signed [31:0] imp_y,
  input  logic signed [31:0] imp_z,
  input  pifs_pkg::cmd_t     cmd,
  output pifs_pkg::status_t  st,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] elev_out,
  output logic signed [31:0] imp_x_out,
  output logic signed [31:0] imp_y_out,
  output logic signed [31:0] imp_v_out
);

  localparam int PW = 66;
  localparam int SW = pifs_pkg::SUM_W;

  logic [30:0]        mass_r, rm_r;
  logic signed [31:0] drift_x_r, drift_y_r, drift_z_r, emit_x_r, emit_y_r;
  logic signed [31:0] px_r, py_r, elev_r, ix_r, iy_r, iv_r;
  logic signed [PW-1:0] dx_r, dy_r, dv_r, prod_r;
  pifs_pkg::mul_sel_t psel_r;
  logic               pvld_r;
  logic [63:0]        sqx_r, sqy_r, sq_r, nx_r, ny_r, sval_r;
  logic [61:0]        mm_r;
  logic               sq_gt_r;
  logic [31:0]        root_r, drem_r, dlo_r, q_r, qx_r;
  logic [35:0]        srem_r;

  logic [31:0]          ax, ay, av;
  logic signed [32:0]   ma, mb;
  logic signed [PW-1:0] prod_c;
  logic [35:0]          rem_sh, trial;
  logic [32:0]          d2;

  assign st.sq_gt = sq_gt_r;

  assign ax = ix_r[31] ? (~ix_r + 32'd1) : ix_r;
  assign ay = iy_r[31] ? (~iy_r + 32'd1) : iy_r;
  assign av = iv_r[31] ? (~iv_r + 32'd1) : iv_r;

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      pifs_pkg::MUL_IX_RM: begin ma = {ix_r[31], ix_r}; mb = {2'b00, rm_r}; end
      pifs_pkg::MUL_IY_RM: begin ma = {iy_r[31], iy_r}; mb = {2'b00, rm_r}; end
      pifs_pkg::MUL_IV_RM: begin ma = {iv_r[31], iv_r}; mb = {2'b00, rm_r}; end
      pifs_pkg::MUL_AX_AX: begin ma = {1'b0, ax}; mb = {1'b0, ax}; end
      pifs_pkg::MUL_AY_AY: begin ma = {1'b0, ay}; mb = {1'b0, ay}; end
      pifs_pkg::MUL_M_M:   begin ma = {2'b00, mass_r}; mb = {2'b00, mass_r}; end
      pifs_pkg::MUL_M_AX:  begin ma = {2'b00, mass_r}; mb = {1'b0, ax}; end
      default:             begin ma = {2'b00, mass_r}; mb = {1'b0, ay}; end
    endcase
  end

  assign prod_c = PW'(ma) * PW'(mb);

  // square root and divide step logic
  assign rem_sh = {srem_r[33:0], sval_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign d2     = {drem_r, dlo_r[31]};

  function automatic logic signed [31:0] shorten(input logic signed [31:0] c,
                                                 input logic [31:0] dec);
    logic [31:0] a;
    logic [31:0] d;
    logic [31:0] r;
    a = c[31] ? (~c + 32'd1) : c;
    d = (dec > a) ? a : dec;
    r = a - d;
    return c[31] ? (~r + 32'd1) : r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r    <= 31'(1) << FRAC_BITS;
      rm_r      <= 31'(1) << FRAC_BITS;
      drift_x_r <= '0;
      drift_y_r <= '0;
      drift_z_r <= '0;
      emit_x_r  <= '0;
      emit_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pifs_pkg::CFG_MASS:       mass_r    <= cfg_data[30:0];
        pifs_pkg::CFG_RECIP_MASS: rm_r      <= cfg_data[30:0];
        pifs_pkg::CFG_DRIFT_X:    drift_x_r <= cfg_data;
        pifs_pkg::CFG_DRIFT_Y:    drift_y_r <= cfg_data;
        pifs_pkg::CFG_DRIFT_Z:    drift_z_r <= cfg_data;
        pifs_pkg::CFG_EMITTER_X:  emit_x_r  <= cfg_data;
        pifs_pkg::CFG_EMITTER_Y:  emit_y_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // particle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      py_r   <= '0;
      elev_r <= '0;
      ix_r   <= '0;
      iy_r   <= '0;
      iv_r   <= '0;
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= (cmd.op == pifs_pkg::OP_MUL);
      case (cmd.op)
        pifs_pkg::OP_UPD_A: begin
          px_r   <= pifs_pkg::sat32(SW'(px_r) + SW'(dx_r) + SW'(drift_x_r));
          elev_r <= pifs_pkg::sat32(SW'(elev_r) + SW'(dv_r) + SW'(drift_z_r));
        end
        pifs_pkg::OP_UPD_B: begin
          py_r <= pifs_pkg::sat32(SW'(py_r) + SW'(dy_r) + SW'(drift_y_r) + SW'(elev_r));
        end
        pifs_pkg::OP_FRIC: begin
          if (sq_gt_r) begin
            ix_r <= shorten(ix_r, qx_r);
            iy_r <= shorten(iy_r, q_r);
          end else begin
            ix_r <= '0;
            iy_r <= '0;
          end
          if ({1'b0, av} > {2'b00, mass_r}) begin
            if (!iv_r[31] && (iv_r != 32'sd0)) begin
              iv_r <= 32'({iv_r[31], iv_r} - {2'b00, mass_r});
            end else begin
              iv_r <= 32'({iv_r[31], iv_r} + {2'b00, mass_r});
            end
          end else begin
            iv_r <= '0;
          end
        end
        pifs_pkg::OP_LOAD: begin
          ix_r <= imp_x;
          iy_r <= imp_y;
          iv_r <= imp_z;
        end
        pifs_pkg::OP_REFRESH: begin
          px_r   <= emit_x_r;
          py_r   <= emit_y_r;
          elev_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.op == pifs_pkg::OP_MUL) begin
      prod_r <= prod_c;
      psel_r <= cmd.mul_sel;
    end
    if (pvld_r) begin
      case (psel_r)
        pifs_pkg::MUL_IX_RM: dx_r  <= prod_r >>> FRAC_BITS;
        pifs_pkg::MUL_IY_RM: dy_r  <= prod_r >>> FRAC_BITS;
        pifs_pkg::MUL_IV_RM: dv_r  <= prod_r >>> FRAC_BITS;
        pifs_pkg::MUL_AX_AX: sqx_r <= prod_r[63:0];
        pifs_pkg::MUL_AY_AY: sqy_r <= prod_r[63:0];
        pifs_pkg::MUL_M_M:   mm_r  <= prod_r[61:0];
        pifs_pkg::MUL_M_AX:  nx_r  <= prod_r[63:0];
        default:             ny_r  <= prod_r[63:0];
      endcase
    end
    case (cmd.op)
      pifs_pkg::OP_UPD_B: begin
        sq_r    <= sqx_r + sqy_r;
        sq_gt_r <= ({1'b0, sqx_r} + {1'b0, sqy_r}) > {3'b000, mm_r};
      end
      pifs_pkg::OP_SQRT_INIT: begin
        sval_r <= sq_r;
        root_r <= '0;
        srem_r <= '0;
      end
      pifs_pkg::OP_SQRT_STEP: begin
        sval_r <= {sval_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_r <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      pifs_pkg::OP_DIV_INIT_X: begin
        drem_r <= nx_r[63:32];
        dlo_r  <= nx_r[31:0];
        q_r    <= '0;
      end
      pifs_pkg::OP_DIV_INIT_Y: begin
        qx_r   <= q_r;
        drem_r <= ny_r[63:32];
        dlo_r  <= ny_r[31:0];
        q_r    <= '0;
      end
      pifs_pkg::OP_DIV_STEP: begin
        dlo_r <= {dlo_r[30:0], 1'b0};
        if (d2 >= {1'b0, root_r}) begin
          drem_r <= 32'(d2 - {1'b0, root_r});
          q_r    <= {q_r[30:0], 1'b1};
        end else begin
          drem_r <= d2[31:0];
          q_r    <= {q_r[30:0], 1'b0};
        end
      end
      pifs_pkg::OP_OUT: begin
        pos_x     <= px_r;
        pos_y     <= py_r;
        elev_out  <= elev_r;
        imp_x_out <= ix_r;
        imp_y_out <= iy_r;
        imp_v_out <= iv_r;
      end
      default: ;
    endcase
  end

endmodule

@@ src/particle_impulse_friction_step.sv @@
// top level of the particle impulse friction step block
// a step item either zeroes its planar impulse or shortens it; a shortened item also runs
// 32 root steps and two 32 step divides before its friction update. load, refresh and
// unused request codes go from the input transfer straight to the finish state.
// one item at a time; the next input transfer can come in the same cycle the result is up,
// and a finished result waits in the output register while the next item is taken; an item
// done before it is taken waits. synchronous active low reset gives mass and recip_mass 1.0
module particle_impulse_friction_step #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  pifs_in_if.sink     in_chan,
  pifs_out_if.source  out_chan,
  pifs_cfg_if.sink    cfg_chan
);

  pifs_pkg::cmd_t    cmd;
  pifs_pkg::status_t st;

  // config writes are always taken
  assign cfg_chan.ready = 1'b1;

  // sequencer: walks multiplies, root and divide iterations
  pifs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .cmd         (cmd),
    .st          (st)
  );

  // arithmetic and state
  pifs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .imp_x     (in_chan.impulse_x),
    .imp_y     (in_chan.impulse_y),
    .imp_z     (in_chan.impulse_z),
    .cmd       (cmd),
    .st        (st),
    .pos_x     (out_chan.pos_x),
    .pos_y     (out_chan.pos_y),
    .elev_out  (out_chan.elev_out),
    .imp_x_out (out_chan.imp_x_out),
    .imp_y_out (out_chan.imp_y_out),
    .imp_v_out (out_chan.imp_v_out)
  );

endmodule

@@ src/pifs_checker.sv @@
// port level checks of the particle step block and their binding
module pifs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a result is held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result only comes out of a busy block
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in flight");

endmodule

bind particle_impulse_friction_step pifs_checker u_pifs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
